### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the merge sort engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSORT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSORT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// Shared constants and types of the merge sort engine.
// ----------------------------------------------------------------------------
package msort_pkg;

    // Width of one stored element.
    localparam int DATA_W = 32;

    // Default number of elements the store holds.
    localparam int DEFAULT_DEPTH = 64;

    // Status that the pass sequencer reports to the top level.
    typedef struct packed {
        logic done;   // last merge pass finished this cycle
        logic src;    // bank holding the current run data (0: bank A, 1: bank B)
    } msort_seq_stat_t;

endpackage

### rtl/msort_bank.sv
// ----------------------------------------------------------------------------
// msort_bank
// Element memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module msort_bank
    import msort_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr0,
    input  logic [AW-1:0]     raddr1,
    output logic [DATA_W-1:0] rdata0,
    output logic [DATA_W-1:0] rdata1
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge aclk) begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

### rtl/msort_seq.sv
// ----------------------------------------------------------------------------
// msort_seq
// Bottom-up merge pass sequencer with one shared signed comparator.
// ----------------------------------------------------------------------------
module msort_seq
    import msort_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CW-1:0]     n_in,
    input  logic [DATA_W-1:0] rd0,
    input  logic [DATA_W-1:0] rd1,
    output logic [AW-1:0]     raddr0,
    output logic [AW-1:0]     raddr1,
    output logic              we,
    output logic [AW-1:0]     waddr,
    output logic [DATA_W-1:0] wdata,
    output msort_seq_stat_t   stat
);

`include "assert_macros.svh"

    // Wide enough for a run end plus twice the run width.
    localparam int EW = CW + 2;

    typedef enum logic [2:0] {
        SQ_IDLE  = 3'b001,
        SQ_PREP  = 3'b010,
        SQ_MERGE = 3'b100
    } seq_state_t;

    seq_state_t    state_reg, state_next;
    logic          src_reg, src_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;

    logic          take_left;
    logic          finish;
    logic [CW-1:0] k_inc;
    logic [EW-1:0] w2;

    // Clamp a run boundary to the element count.
    function automatic logic [CW-1:0] clamp_n(input logic [EW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [EW-1:0] bx;
        bx = {2'b00, b};
        return (a < bx) ? a[CW-1:0] : b;
    endfunction

    // Shared comparator: stable choice of the left run on equal values.
    assign take_left = (i_reg < mid_reg) &&
                       (!(j_reg < hi_reg) || ($signed(rd0) <= $signed(rd1)));
    assign k_inc = k_reg + CW'(1);
    assign w2    = {1'b0, w_reg, 1'b0};

    // Pass, run and element sequencing.
    always_comb begin
        state_next = state_reg;
        src_next   = src_reg;
        n_next     = n_reg;
        w_next     = w_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        we         = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    n_next   = n_in;
                    src_next = 1'b0;
                    w_next   = CW'(1);
                    i_next   = '0;
                    k_next   = '0;
                    mid_next = CW'(1);
                    j_next   = CW'(1);
                    hi_next  = CW'(2);
                    if (n_in >= CW'(2)) begin
                        state_next = SQ_PREP;
                    end
                end
            end
            SQ_PREP: begin
                state_next = SQ_MERGE;
            end
            SQ_MERGE: begin
                we     = 1'b1;
                i_next = i_reg + CW'(take_left);
                j_next = j_reg + CW'(!take_left);
                k_next = k_inc;
                if (k_inc == hi_reg) begin
                    if (hi_reg == n_reg) begin
                        // End of a pass: the destination bank becomes the source.
                        src_next = !src_reg;
                        if (w2 >= {2'b00, n_reg}) begin
                            finish     = 1'b1;
                            state_next = SQ_IDLE;
                        end else begin
                            w_next     = w2[CW-1:0];
                            i_next     = '0;
                            k_next     = '0;
                            mid_next   = clamp_n(w2, n_reg);
                            j_next     = clamp_n(w2, n_reg);
                            hi_next    = clamp_n({w2[EW-2:0], 1'b0}, n_reg);
                            state_next = SQ_PREP;
                        end
                    end else begin
                        // Next pair of runs in the same pass.
                        i_next   = hi_reg;
                        k_next   = hi_reg;
                        mid_next = clamp_n(EW'(hi_reg) + EW'(w_reg), n_reg);
                        j_next   = clamp_n(EW'(hi_reg) + EW'(w_reg), n_reg);
                        hi_next  = clamp_n(EW'(hi_reg) + w2, n_reg);
                    end
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Read addresses follow the next pointers so that the registered read data lines up with the pointer registers.
    assign raddr0 = i_next[AW-1:0];
    assign raddr1 = j_next[AW-1:0];
    assign waddr  = k_reg[AW-1:0];
    assign wdata  = take_left ? rd0 : rd1;

    assign stat.done = finish;
    assign stat.src  = src_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            src_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    // Pointers and run bounds.
    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        w_reg   <= w_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
    end

    // Checks on the merge sequencing.
    `MSORT_ASSERT_NOW(a_merge_in_run, aclk, aresetn, state_reg == SQ_MERGE,
        (k_reg < hi_reg) && (i_reg <= mid_reg) && (j_reg <= hi_reg),
        "merge pointer left its run")
    `MSORT_ASSERT_NOW(a_merge_count, aclk, aresetn, state_reg == SQ_MERGE,
        (i_reg + j_reg == k_reg + mid_reg),
        "merge output index does not match consumed elements")
    `MSORT_ASSERT_NEXT(a_done_idle, aclk, aresetn, stat.done,
        state_reg == SQ_IDLE,
        "sequencer did not return to idle after the last pass")

endmodule

### rtl/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects signed 32-bit values, merge-sorts them and streams them out.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers on s_axis carry one value each in s_axis_tdata; s_axis_tlast
//   marks the final value of a set. Up to DEPTH values are stored, one per cycle;
//   further values of the set are dropped and flag overflow on every result.
//   After the final transfer s_axis_tready stays low while the set is sorted
//   by bottom-up merge passes that ping-pong between two memory banks, using
//   one shared comparator. Each pass is a prepare step followed by the merge
//   of all n elements, and ceil(log2(n)) passes are made.
//   Results then leave m_axis one per cycle in ascending order, equal values
//   in arrival order, with m_axis_tlast on the final one and the overflow flag
//   in m_axis_tuser. The output register holds a result while m_axis_tready is
//   low and the read sequence waits. Once the last result is in the output
//   register, s_axis_tready rises for the next set.
//   A synchronous active-low reset empties the store and clears the channels.
// ----------------------------------------------------------------------------
module merge_sort_engine
    import msort_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,   // last_result
    output logic [0:0]  m_axis_tuser    // [0] overflow
);

`include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SORT  = 4'b0010,
        ST_OPREP = 4'b0100,
        ST_OUT   = 4'b1000
    } top_state_t;

    top_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [CW-1:0]     oidx_reg, oidx_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_last_reg;
    logic              m_ovf_reg;

    logic              in_xfer;
    logic              has_room;
    logic              load_we;
    logic [CW-1:0]     count_after;
    logic              seq_start;
    logic              can_load;
    logic              out_load;
    logic [CW-1:0]     oidx_inc;

    logic [AW-1:0]     addr0;
    logic [AW-1:0]     seq_raddr0, seq_raddr1;
    logic              seq_we;
    logic [AW-1:0]     seq_waddr;
    logic [DATA_W-1:0] seq_wdata;
    msort_seq_stat_t   seq_stat;

    logic              a_we;
    logic [AW-1:0]     a_waddr;
    logic [DATA_W-1:0] a_wdata;
    logic [DATA_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [DATA_W-1:0] src_rd0, src_rd1;

    // Input side handshake and store bookkeeping.
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign has_room      = (count_reg < CW'(DEPTH));
    assign load_we       = in_xfer && has_room;
    assign count_after   = has_room ? (count_reg + CW'(1)) : count_reg;
    assign seq_start     = in_xfer && s_axis_tlast;
    assign can_load      = !m_valid_reg || m_axis_tready;
    assign oidx_inc      = oidx_reg + CW'(1);

    // Block sequencing: load, sort (skipped for fewer than two values), drain.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        oidx_next  = oidx_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    count_next = count_after;
                    if (!has_room) begin
                        drop_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        oidx_next  = '0;
                        state_next = (count_after >= CW'(2)) ? ST_SORT : ST_OPREP;
                    end
                end
            end
            ST_SORT: begin
                if (seq_stat.done) begin
                    state_next = ST_OPREP;
                end
            end
            ST_OPREP: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (can_load) begin
                    out_load  = 1'b1;
                    oidx_next = oidx_inc;
                    if (oidx_inc == count_reg) begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Output valid follows loads and completed transfers.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Memory port selection between loading, merging and draining.
    assign addr0   = ((state_reg == ST_OPREP) || (state_reg == ST_OUT)) ?
                     oidx_next[AW-1:0] : seq_raddr0;
    assign a_we    = load_we || (seq_we && seq_stat.src);
    assign a_waddr = load_we ? count_reg[AW-1:0] : seq_waddr;
    assign a_wdata = load_we ? s_axis_tdata : seq_wdata;
    assign src_rd0 = seq_stat.src ? b_rd0 : a_rd0;
    assign src_rd1 = seq_stat.src ? b_rd1 : a_rd1;

    msort_bank #(
        .DEPTH (DEPTH)
    ) u_bank_a (
        .aclk   (aclk),
        .we     (a_we),
        .waddr  (a_waddr),
        .wdata  (a_wdata),
        .raddr0 (addr0),
        .raddr1 (seq_raddr1),
        .rdata0 (a_rd0),
        .rdata1 (a_rd1)
    );

    msort_bank #(
        .DEPTH (DEPTH)
    ) u_bank_b (
        .aclk   (aclk),
        .we     (seq_we && !seq_stat.src),
        .waddr  (seq_waddr),
        .wdata  (seq_wdata),
        .raddr0 (addr0),
        .raddr1 (seq_raddr1),
        .rdata0 (b_rd0),
        .rdata1 (b_rd1)
    );

    msort_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seq_start),
        .n_in    (count_after),
        .rd0     (src_rd0),
        .rd1     (src_rd1),
        .raddr0  (seq_raddr0),
        .raddr1  (seq_raddr1),
        .we      (seq_we),
        .waddr   (seq_waddr),
        .wdata   (seq_wdata),
        .stat    (seq_stat)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Read index and output payload.
    always_ff @(posedge aclk) begin
        oidx_reg <= oidx_next;
        if (out_load) begin
            m_data_reg <= src_rd0;
            m_last_reg <= (oidx_inc == count_reg);
            m_ovf_reg  <= drop_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tlast    = m_last_reg;
    assign m_axis_tuser[0] = m_ovf_reg;

    // Checks on the block sequencing.
    `MSORT_ASSERT_NEXT(a_full_drops, aclk, aresetn, in_xfer && !has_room && !s_axis_tlast,
        drop_reg, "transfer into a full store did not raise overflow")
    `MSORT_ASSERT_NOW(a_done_in_sort, aclk, aresetn, seq_stat.done,
        state_reg == ST_SORT, "sort finished outside the sort phase")
    `MSORT_ASSERT_NOW(a_drain_nonempty, aclk, aresetn,
        (state_reg == ST_OUT) || (state_reg == ST_OPREP),
        (count_reg != '0) && (oidx_reg < count_reg),
        "drain phase with an empty set or index past the set")

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the merge sort engine. Sets of signed values are
// streamed in, and every sorted value that leaves the block is checked
// against an ascending, arrival-stable ordering that is built in parallel.
// The sets cover single-element and full sets, sets past the store depth,
// extreme values and duplicates, random pauses on both sides, a long hold-off
// on the result side and a full drain pause on the input side.
// ----------------------------------------------------------------------------
module testbench;
    import msort_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = DEFAULT_DEPTH;
    localparam int ITEM_TARGET = 250;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_GAP = 12;

    // Value styles for a random set.
    typedef enum int {
        STYLE_FULL,
        STYLE_NARROW,
        STYLE_EXTREME
    } value_style_t;

    // Expected sorted values of completed sets, oldest first.
    class sort_scoreboard;
        typedef struct {
            logic signed [31:0] value;
            bit                 last;
            bit                 overflow;
        } sorted_entry_t;

        int                 depth;
        logic signed [31:0] ordered_set[$];
        bit                 dropped;
        sorted_entry_t      expected_values[$];
        int                 error_count;

        function new(int depth_i);
            depth = depth_i;
            dropped = 0;
            error_count = 0;
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        function int pending();
            return expected_values.size();
        endfunction

        // Keeps the stored set in order; an equal value goes behind the
        // earlier ones so that arrival order is kept among duplicates.
        function void note_input(logic signed [31:0] value, bit last_item);
            int            pos;
            int            n;
            sorted_entry_t entry;
            if (ordered_set.size() < depth) begin
                pos = ordered_set.size();
                for (int i = 0; i < ordered_set.size(); i++) begin
                    if (ordered_set[i] > value) begin
                        pos = i;
                        break;
                    end
                end
                ordered_set.insert(pos, value);
            end else begin
                dropped = 1;
            end
            if (last_item) begin
                n = ordered_set.size();
                for (int k = 0; k < n; k++) begin
                    entry.value = ordered_set[k];
                    entry.last = (k == n - 1);
                    entry.overflow = dropped;
                    expected_values.insert(expected_values.size(), entry);
                end
                ordered_set.delete();
                dropped = 0;
            end
        endfunction

        task check_result(logic signed [31:0] value, bit last_result,
                          bit overflow);
            sorted_entry_t entry;
            if (expected_values.size() == 0) begin
                report($sformatf("unexpected result value=%0d", value));
                return;
            end
            entry = expected_values.pop_front();
            if (value !== entry.value)
                report($sformatf("sorted value %0d, expected %0d", value, entry.value));
            if (last_result !== entry.last)
                report($sformatf("last flag %0b, expected %0b (value %0d)",
                                 last_result, entry.last, entry.value));
            if (overflow !== entry.overflow)
                report($sformatf("overflow flag %0b, expected %0b (value %0d)",
                                 overflow, entry.overflow, entry.value));
        endtask

        task check_drained();
            if (expected_values.size() != 0)
                report($sformatf("%0d sorted values never arrived",
                                 expected_values.size()));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        s_axis_tlast;   // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] sorted_value
    logic        m_axis_tlast;   // last_result
    logic [0:0]  m_axis_tuser;   // [0] overflow

    sort_scoreboard sorted_board = new(STORE_DEPTH);

    int items_sent = 0;
    bit sender_no_gaps = 0;
    int hold_cycles = 0;
    int receiver_wait = 0;
    bit receiver_no_gaps = 0;
    int results_taken = 0;
    int idle_cycles = 0;

    merge_sort_engine u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Both channels are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sorted_board.note_input(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                sorted_board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                results_taken++;
                // Switch between gapless and gappy stretches now and then.
                if (results_taken % 20 == 0)
                    receiver_no_gaps = ($urandom_range(0, 2) == 0);
                receiver_wait = receiver_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
    end

    // Result side: a long hold-off when asked for, else a random wait per
    // transfer, counted down at the falling edge.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_axis_tready = 0;
            hold_cycles--;
        end else if (receiver_wait > 0) begin
            m_axis_tready = 0;
            receiver_wait--;
        end else begin
            m_axis_tready = 1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one value and waits until it is taken.
    task automatic send_item(input logic [31:0] value, input bit last_item);
        int gap;
        gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = value;
        s_axis_tlast = last_item;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] draw_value(value_style_t style);
        logic [31:0] value;
        case (style)
            STYLE_NARROW: value = $urandom_range(0, 8) - 4;
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: value = 32'h7FFF_FFFF;
                    1: value = 32'h8000_0000;
                    2: value = 32'h0000_0000;
                    3: value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
            end
            default: value = $urandom;
        endcase
        return value;
    endfunction

    task automatic send_set(input int n);
        value_style_t style;
        style = value_style_t'($urandom_range(0, 2));
        for (int i = 0; i < n; i++)
            send_item(draw_value(style), i == n - 1);
    endtask

    // Holds the input back until every expected value has come out.
    task automatic wait_drained();
        s_axis_tvalid = 0;
        while (sorted_board.pending() != 0) @(negedge aclk);
    endtask

    initial begin
        int set_index;
        int size_draw;
        int set_size;

        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed sets: single elements, extremes, duplicates, reverse order.
        send_item(32'h7FFF_FFFF, 1);
        send_item(32'h8000_0000, 1);
        send_item(32'h0000_0000, 0);
        send_item(32'h7FFF_FFFF, 0);
        send_item(32'h8000_0000, 0);
        send_item(32'hFFFF_FFFF, 0);
        send_item(32'h0000_0001, 0);
        send_item(32'hFFFF_FFFF, 0);
        send_item(32'h8000_0000, 0);
        send_item(32'h0000_0000, 0);
        send_item(32'h7FFF_FFFF, 0);
        send_item(32'h0000_0001, 1);
        send_item(32'h0000_0003, 0);
        send_item(32'h0000_0002, 0);
        send_item(32'h0000_0001, 0);
        send_item(32'h0000_0000, 1);
        send_item(32'hAAAA_AAAA, 0);
        send_item(32'h5555_5555, 1);

        // The sender pauses until everything is out, then the receiver holds
        // off while two sets are offered back to back.
        wait_drained();
        sender_no_gaps = 1;
        hold_cycles = 300;
        send_set(20);
        send_set(5);

        // One exactly full set, then one that runs past the store depth.
        sender_no_gaps = 0;
        send_set(STORE_DEPTH);
        send_set(STORE_DEPTH + 5);

        set_index = 0;
        while (items_sent < ITEM_TARGET) begin
            sender_no_gaps = ($urandom_range(0, 3) == 0);
            size_draw = $urandom_range(0, 99);
            if (size_draw < 3)
                set_size = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 8);
            else if (size_draw < 20)
                set_size = $urandom_range(13, 40);
            else
                set_size = $urandom_range(1, 12);
            send_set(set_size);
            set_index++;
            if (set_index == 6)
                wait_drained();
        end

        s_axis_tvalid = 0;
        s_axis_tlast = 0;
        while (sorted_board.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        sorted_board.check_drained();
        if (sorted_board.error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
